[design/bed_pkg.sv]
// Package for the backslash escape decoder: beat payload types, result bundle
// type, register indexes and sizing constants. No dependencies.
`default_nettype none
package bed_pkg;

  // most result beats one input beat can cause
  localparam int RES_MAX = 3;
  localparam int RES_CNT_W = 2;
  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPES_ENABLED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_APPEND_NEWLINE  = 1'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_item_t;

  // all result beats of one input beat
  typedef struct packed {
    logic [RES_MAX-1:0][7:0] bytes;
    logic [RES_MAX-1:0]      vld;
    logic [RES_CNT_W-1:0]    cnt;
    logic                    last;
  } bundle_t;

endpackage
`default_nettype wire

[design/bed_front.sv]
// Front of the backslash escape decoder: holds the config registers and the
// escape parse state, turns each input beat into a bundle of results.
// Depends on bed_pkg.
`default_nettype none
module bed_front (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire [bed_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  wire                               cfg_wdata,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  bed_pkg::in_item_t                 in_data,
  input  wire                               q_full,
  output logic                              q_push,
  output bed_pkg::bundle_t                  q_wdata
);
  import bed_pkg::*;

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_BSLASH = 3'd1;
  localparam logic [2:0] MODE_OCTAL  = 3'd2;
  localparam logic [2:0] MODE_HEX    = 3'd3;
  localparam logic [2:0] MODE_DROP   = 3'd4;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] ASC_NL    = 8'h0A;
  localparam logic [7:0] ASC_TAB   = 8'h09;
  localparam logic [7:0] ASC_CR    = 8'h0D;
  localparam logic [7:0] ASC_BEL   = 8'h07;
  localparam logic [7:0] ASC_BS    = 8'h08;
  localparam logic [7:0] ASC_VT    = 8'h0B;
  localparam logic [7:0] ASC_FF    = 8'h0C;

  // append one result to a bundle, dropping it once the bundle is full
  function automatic bundle_t put_res(bundle_t bu, logic [7:0] b, logic v);
    bundle_t r;
    r = bu;
    if (bu.cnt < RES_CNT_W'(RES_MAX)) begin
      r.bytes[bu.cnt] = b;
      r.vld[bu.cnt]   = v;
      r.cnt           = bu.cnt + 2'd1;
    end
    return r;
  endfunction

  logic       esc_en_r, append_nl_r;
  logic [2:0] mode_r, mode_nxt;
  logic [1:0] dig_r, dig_nxt;
  logic [8:0] val_r, val_nxt;

  logic       accept;
  logic [7:0] b;
  logic       is_oct, is_hex;
  logic [3:0] hex_val;
  logic [8:0] oct_acc, hex_acc;
  logic [1:0] dig_inc;
  bundle_t    bu;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign b        = in_data.data_byte;

  // digit classification
  always_comb begin
    is_oct  = (b >= CH_0) && (b <= CH_7);
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if ((b >= CH_0) && (b <= CH_9)) begin
      hex_val = 4'(b - CH_0);
    end else if ((b >= CH_LA) && (b <= CH_LF_HEX)) begin
      hex_val = 4'(b - CH_LA + 8'd10);
    end else if ((b >= CH_UA) && (b <= CH_UF)) begin
      hex_val = 4'(b - CH_UA + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
    oct_acc = {val_r[5:0], 3'b000} + {6'd0, b[2:0]};
    hex_acc = {val_r[4:0], 4'b0000} + {5'd0, hex_val};
    dig_inc = dig_r + 2'd1;
  end

  // parse one beat
  always_comb begin
    mode_nxt = mode_r;
    dig_nxt  = dig_r;
    val_nxt  = val_r;
    bu       = '0;
    if (!esc_en_r) begin
      mode_nxt = MODE_NORMAL;
      dig_nxt  = 2'd0;
      val_nxt  = 9'd0;
      if (in_data.byte_present) bu = put_res(bu, b, 1'b1);
    end else if (in_data.byte_present) begin
      unique case (mode_r) inside
        MODE_BSLASH: begin
          mode_nxt = MODE_NORMAL;
          unique case (b)
            CH_N:      bu = put_res(bu, ASC_NL, 1'b1);
            CH_T:      bu = put_res(bu, ASC_TAB, 1'b1);
            CH_R:      bu = put_res(bu, ASC_CR, 1'b1);
            CH_BSLASH: bu = put_res(bu, CH_BSLASH, 1'b1);
            CH_A:      bu = put_res(bu, ASC_BEL, 1'b1);
            CH_B:      bu = put_res(bu, ASC_BS, 1'b1);
            CH_V:      bu = put_res(bu, ASC_VT, 1'b1);
            CH_F:      bu = put_res(bu, ASC_FF, 1'b1);
            CH_C:      mode_nxt = MODE_DROP;
            CH_0: begin
              mode_nxt = MODE_OCTAL;
              dig_nxt  = 2'd1;
              val_nxt  = 9'd0;
            end
            CH_X: begin
              mode_nxt = MODE_HEX;
              dig_nxt  = 2'd0;
              val_nxt  = 9'd0;
            end
            default: begin
              // unknown escape keeps both characters
              bu = put_res(bu, CH_BSLASH, 1'b1);
              bu = put_res(bu, b, 1'b1);
            end
          endcase
        end
        MODE_OCTAL, MODE_HEX: begin
          if ((mode_r == MODE_OCTAL) ? is_oct : is_hex) begin
            val_nxt = (mode_r == MODE_OCTAL) ? oct_acc : hex_acc;
            dig_nxt = dig_inc;
            if (((mode_r == MODE_OCTAL) && (dig_inc == 2'd3)) ||
                ((mode_r == MODE_HEX) && (dig_inc >= 2'd2))) begin
              bu       = put_res(bu, val_nxt[7:0], 1'b1);
              mode_nxt = MODE_NORMAL;
              dig_nxt  = 2'd0;
              val_nxt  = 9'd0;
            end
          end else begin
            // non-digit closes the escape, then is plain text or opens a new escape
            bu       = put_res(bu, val_r[7:0], 1'b1);
            mode_nxt = MODE_NORMAL;
            dig_nxt  = 2'd0;
            val_nxt  = 9'd0;
            if (b == CH_BSLASH) mode_nxt = MODE_BSLASH;
            else bu = put_res(bu, b, 1'b1);
          end
        end
        MODE_DROP: ;
        default: begin
          mode_nxt = MODE_NORMAL;
          if (b == CH_BSLASH) mode_nxt = MODE_BSLASH;
          else bu = put_res(bu, b, 1'b1);
        end
      endcase
    end

    // end of message: flush pending escape, newline, end marker
    if (in_data.end_of_message) begin
      if (mode_nxt == MODE_BSLASH) begin
        bu = put_res(bu, CH_BSLASH, 1'b1);
      end else if ((mode_nxt == MODE_OCTAL) || (mode_nxt == MODE_HEX)) begin
        bu = put_res(bu, val_nxt[7:0], 1'b1);
      end
      if (append_nl_r && (mode_nxt != MODE_DROP)) bu = put_res(bu, ASC_NL, 1'b1);
      if (bu.cnt == 2'd0) bu = put_res(bu, 8'd0, 1'b0);
      bu.last  = 1'b1;
      mode_nxt = MODE_NORMAL;
      dig_nxt  = 2'd0;
      val_nxt  = 9'd0;
    end
  end

  assign q_push  = accept && (bu.cnt != 2'd0);
  assign q_wdata = bu;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_en_r    <= 1'b0;
      append_nl_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ESCAPES_ENABLED: esc_en_r    <= cfg_wdata;
        REG_APPEND_NEWLINE:  append_nl_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      dig_r  <= 2'd0;
      val_r  <= 9'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      dig_r  <= dig_nxt;
      val_r  <= val_nxt;
    end
  end

`ifndef SYNTHESIS
  // end of message always leaves the parser in normal text mode
  a_eom_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.end_of_message |=> (mode_r == MODE_NORMAL) && (dig_r == 2'd0))
    else $error("parse state not cleared at end of message");
  // a message end always yields a bundle
  a_eom_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.end_of_message |-> q_push)
    else $error("end of message without a result");
`endif

endmodule
`default_nettype wire

[design/bed_queue.sv]
// Small register queue of result bundles between front and back of the
// backslash escape decoder. Depends on bed_pkg.
`default_nettype none
module bed_queue #(
  parameter int DEPTH = bed_pkg::QUEUE_DEPTH_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  input  bed_pkg::bundle_t  wdata,
  output logic              full,
  input  wire               pop,
  output logic              empty,
  output bed_pkg::bundle_t  head
);
  import bed_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t              mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue pop while empty");
  // queued bundles always hold at least one result
  a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (head.cnt != '0))
    else $error("empty bundle in queue");
`endif

endmodule
`default_nettype wire

[design/bed_back.sv]
// Back of the backslash escape decoder: walks through the results of the
// bundle at the queue head, one beat per cycle while out_stall is low, into
// the output register. Depends on bed_pkg.
`default_nettype none
module bed_back (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                q_empty,
  input  bed_pkg::bundle_t   q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire                out_stall,
  output bed_pkg::out_item_t out_data
);
  import bed_pkg::*;

  logic [RES_CNT_W-1:0] idx_r, idx_nxt;
  logic                 out_vld_r;
  out_item_t            out_data_r, out_nxt;
  logic                 load, take, at_end;

  assign load   = !out_vld_r || !out_stall;
  assign take   = load && !q_empty;
  assign at_end = (idx_r == q_head.cnt - 2'd1);
  assign q_pop  = take && at_end;

  // select current result of the head bundle
  always_comb begin
    out_nxt.out_byte  = q_head.bytes[idx_r];
    out_nxt.out_valid = q_head.vld[idx_r];
    out_nxt.out_last  = q_head.last && at_end;
    idx_nxt = idx_r;
    if (take) idx_nxt = at_end ? '0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      if (load) out_vld_r <= !q_empty;
      idx_r <= idx_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (take) out_data_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // result index stays inside the head bundle
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> (idx_r < q_head.cnt))
    else $error("result index past bundle end");
  // index returns to zero whenever a bundle is retired
  a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (idx_r == '0))
    else $error("result index not reset after pop");
`endif

endmodule
`default_nettype wire

[design/backslash_escape_decoder.sv]
// Backslash escape decoder, top level. An input beat goes into the bundle queue
// and its first result beat then through the output register. Throughput: one
// input beat per cycle while out_stall is low and each beat gives at most one
// result; more results per beat keep the one-result-per-cycle back end busy.
// Reset (rst_n low, sync) clears parse state, queue and output valid; escapes
// off, newline on. Depends on bed_pkg, bed_front, bed_queue, bed_back.
`default_nettype none
module backslash_escape_decoder #(
  parameter int QUEUE_DEPTH = bed_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_we,
  input  wire [bed_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire                           cfg_wdata,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  bed_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  wire                           out_stall,
  output bed_pkg::out_item_t            out_data
);
  import bed_pkg::*;

  logic    q_push, q_pop, q_full, q_empty;
  bundle_t q_wdata, q_head;

  // parse and classify
  bed_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // bundle queue
  bed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .head  (q_head)
  );

  // serialize results
  bed_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
